@@ rtl/aie_pkg.sv @@
`default_nettype none
package aie_pkg;

   localparam int REG_COUNT   = 16;
   localparam int MEM_BYTES   = 4096;
   localparam int REG_IDX_W   = $clog2(REG_COUNT);
   localparam int MEM_ADDR_W  = $clog2(MEM_BYTES);
   localparam int DATA_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int OPCODE_W    = 8;
   localparam int STATUS_W    = 3;
   localparam int SHIFT_W     = $clog2(DATA_W);

   // item kinds
   localparam logic KIND_EXEC    = 1'b0;
   localparam logic KIND_PRELOAD = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_NOP  = 8'd0,
      OP_ADD  = 8'd1,
      OP_SUB  = 8'd2,
      OP_OR   = 8'd3,
      OP_AND  = 8'd4,
      OP_SHL  = 8'd5,
      OP_SHR  = 8'd6,
      OP_LT   = 8'd7,
      OP_JMP  = 8'd8,
      OP_CJP  = 8'd9,
      OP_SET  = 8'd10,
      OP_MOV  = 8'd11,
      OP_LD   = 8'd12,
      OP_ST   = 8'd13,
      OP_HALT = 8'd14
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADVANCED = 3'd0,
      ST_JUMPED   = 3'd1,
      ST_HALTED   = 3'd2,
      ST_UNKNOWN  = 3'd3,
      ST_RANGE    = 3'd4
   } status_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/aie_ctrl.sv @@
`default_nettype none
module aie_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output aie_pkg::ctrl_cmd_type       cmd,
   input  wire aie_pkg::dp_status_type dp_status
);
   import aie_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (dp_status.clear_last) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            S_EXEC: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

   always_comb begin
      cmd.clear   = (state_ff == S_CLEAR);
      cmd.capture = (state_ff == S_IDLE) && start;
      cmd.execute = (state_ff == S_EXEC);
   end

endmodule
`default_nettype wire

@@ rtl/aie_dpath.sv @@
`default_nettype none
module aie_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire aie_pkg::ctrl_cmd_type           cmd,
   output aie_pkg::dp_status_type               dp_status,
   input  wire logic                            req_type,
   input  wire logic [aie_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire logic [aie_pkg::DATA_W-1:0]      req_operand_x,
   input  wire logic [aie_pkg::DATA_W-1:0]      req_operand_y,
   output logic                                 rsp_valid,
   output logic [aie_pkg::STATUS_W-1:0]         rsp_status,
   output logic [aie_pkg::DATA_W-1:0]           rsp_next_pc,
   output logic [aie_pkg::DATA_W-1:0]           rsp_acc_value
);
   import aie_pkg::*;

   // captured word
   logic                  kind_ff;
   logic [OPCODE_W-1:0]   op_ff;
   logic [DATA_W-1:0]     x_ff;
   logic [DATA_W-1:0]     y_ff;

   // architectural state
   logic [DATA_W-1:0]     reg_ff [REG_COUNT];
   logic [BYTE_W-1:0]     mem    [MEM_BYTES];
   logic [BYTE_W-1:0]     mem_rd_ff;
   logic [DATA_W-1:0]     pc_ff;
   logic [MEM_ADDR_W-1:0] clr_addr_ff;

   // response registers
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [DATA_W-1:0]     rsp_next_pc_ff;
   logic [DATA_W-1:0]     rsp_acc_value_ff;

   // execute results
   logic                  x_reg;
   logic                  y_reg;
   logic                  x_mem;
   logic [DATA_W-1:0]     acc_a;
   logic [DATA_W-1:0]     acc_b;
   logic                  shift_big;
   logic                  reg_wr_en;
   logic [REG_IDX_W-1:0]  reg_wr_idx;
   logic [DATA_W-1:0]     reg_wr_data;
   logic                  mem_wr_en;
   logic [BYTE_W-1:0]     mem_wr_data;
   status_type            status_in;
   logic [DATA_W-1:0]     pc_in;
   logic [DATA_W-1:0]     acc_in;
   logic                  mem_we;
   logic [MEM_ADDR_W-1:0] mem_wa;
   logic [BYTE_W-1:0]     mem_wd;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_type;
         op_ff   <= req_opcode;
         x_ff    <= req_operand_x;
         y_ff    <= req_operand_y;
      end
   end

   assign x_reg     = (x_ff < DATA_W'(REG_COUNT));
   assign y_reg     = (y_ff < DATA_W'(REG_COUNT));
   assign x_mem     = (x_ff < DATA_W'(MEM_BYTES));
   assign acc_a     = reg_ff[0];
   assign acc_b     = reg_ff[1];
   assign shift_big = (acc_b >= DATA_W'(DATA_W));

   always_comb begin
      reg_wr_en   = 1'b0;
      reg_wr_idx  = '0;
      reg_wr_data = y_ff;
      mem_wr_en   = 1'b0;
      mem_wr_data = y_ff[BYTE_W-1:0];
      status_in   = ST_ADVANCED;
      if (kind_ff == KIND_PRELOAD) begin
         if (x_mem) begin
            mem_wr_en = 1'b1;
         end else begin
            status_in = ST_RANGE;
         end
      end else begin
         unique case (op_ff)
            OP_NOP: begin
            end
            OP_ADD: begin
               reg_wr_en   = 1'b1;
               reg_wr_data = acc_a + acc_b;
            end
            OP_SUB: begin
               reg_wr_en   = 1'b1;
               reg_wr_data = acc_a - acc_b;
            end
            OP_OR: begin
               reg_wr_en   = 1'b1;
               reg_wr_data = DATA_W'((acc_a != '0) || (acc_b != '0));
            end
            OP_AND: begin
               reg_wr_en   = 1'b1;
               reg_wr_data = DATA_W'((acc_a != '0) && (acc_b != '0));
            end
            OP_SHL: begin
               reg_wr_en   = 1'b1;
               reg_wr_data = shift_big ? '0 : (acc_a << acc_b[SHIFT_W-1:0]);
            end
            OP_SHR: begin
               reg_wr_en   = 1'b1;
               reg_wr_data = shift_big ? '0 : (acc_a >> acc_b[SHIFT_W-1:0]);
            end
            OP_LT: begin
               reg_wr_en   = 1'b1;
               reg_wr_data = DATA_W'(acc_a < acc_b);
            end
            OP_JMP: begin
               status_in = ST_JUMPED;
            end
            OP_CJP: begin
               if (acc_a != '0) begin
                  status_in = ST_JUMPED;
               end
            end
            OP_SET: begin
               if (x_reg) begin
                  reg_wr_en   = 1'b1;
                  reg_wr_idx  = x_ff[REG_IDX_W-1:0];
                  reg_wr_data = y_ff;
               end else begin
                  status_in = ST_RANGE;
               end
            end
            OP_MOV: begin
               if (x_reg && y_reg) begin
                  reg_wr_en   = 1'b1;
                  reg_wr_idx  = y_ff[REG_IDX_W-1:0];
                  reg_wr_data = reg_ff[x_ff[REG_IDX_W-1:0]];
               end else begin
                  status_in = ST_RANGE;
               end
            end
            OP_LD: begin
               if (x_mem && y_reg) begin
                  reg_wr_en   = 1'b1;
                  reg_wr_idx  = y_ff[REG_IDX_W-1:0];
                  reg_wr_data = DATA_W'(mem_rd_ff);
               end else begin
                  status_in = ST_RANGE;
               end
            end
            OP_ST: begin
               if (x_mem) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = acc_a[BYTE_W-1:0];
               end else begin
                  status_in = ST_RANGE;
               end
            end
            OP_HALT: begin
               status_in = ST_HALTED;
            end
            default: begin
               status_in = ST_UNKNOWN;
            end
         endcase
      end
   end

   // pc: preload and halt hold it, jumps take r1
   always_comb begin
      pc_in = pc_ff;
      if (kind_ff == KIND_EXEC) begin
         if (status_in == ST_JUMPED) begin
            pc_in = acc_b;
         end else if (status_in != ST_HALTED) begin
            pc_in = pc_ff + DATA_W'(1);
         end
      end
   end

   assign acc_in = (reg_wr_en && (reg_wr_idx == '0)) ? reg_wr_data : acc_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_ff[i] <= '0;
         end
         pc_ff <= '0;
      end else if (cmd.execute) begin
         if (reg_wr_en) begin
            reg_ff[reg_wr_idx] <= reg_wr_data;
         end
         pc_ff <= pc_in;
      end
   end

   // byte memory, clearing sweep shares the write port
   assign mem_we = cmd.clear || (cmd.execute && mem_wr_en);
   assign mem_wa = cmd.clear ? clr_addr_ff : x_ff[MEM_ADDR_W-1:0];
   assign mem_wd = cmd.clear ? '0 : mem_wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[req_operand_x[MEM_ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + MEM_ADDR_W'(1);
      end
   end

   assign dp_status.clear_last = cmd.clear && (clr_addr_ff == MEM_ADDR_W'(MEM_BYTES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff    <= status_in;
         rsp_next_pc_ff   <= pc_in;
         rsp_acc_value_ff <= acc_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_next_pc   = rsp_next_pc_ff;
   assign rsp_acc_value = rsp_acc_value_ff;

endmodule
`default_nettype wire

@@ rtl/accumulator_isa_execute_unit.sv @@
`default_nettype none
// accumulator isa execute unit
// input channel: a word is taken at a rising edge with start high and busy low;
//   req_type selects instruction execute or a one-byte preload of data memory,
//   req_opcode, req_operand_x and req_operand_y carry the decoded instruction
// result channel: exactly one word per input word, shown for one cycle on
//   rsp_status, rsp_next_pc and rsp_acc_value with rsp_valid high
// result timing: the execute state follows the accepting edge and registers
//   the result together with the rsp_valid strobe
// word flow: no new word is taken until the last has executed; the byte
//   memory is read synchronously in the accepting cycle and the instruction
//   executes and writes back in the next, during which busy stays high
// reset: registers, pc and accumulator go to zero, then a clearing sweep
//   zeroes the byte memory one entry per cycle, all 4096 entries (MEM_BYTES),
//   with busy high throughout
// the receiver cannot stall: each result is taken in its single strobe cycle
module accumulator_isa_execute_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic [aie_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [aie_pkg::DATA_W-1:0]    req_operand_x,
   input  wire logic [aie_pkg::DATA_W-1:0]    req_operand_y,
   output logic                               rsp_valid,
   output logic [aie_pkg::STATUS_W-1:0]       rsp_status,
   output logic [aie_pkg::DATA_W-1:0]         rsp_next_pc,
   output logic [aie_pkg::DATA_W-1:0]         rsp_acc_value
);
   import aie_pkg::*;

   // controller to datapath commands and back
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // sequencer: clear sweep, idle, execute
   aie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   // register file, byte memory, pc and the result registers
   aie_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .dp_status     (dp_status),
      .req_type      (req_type),
      .req_opcode    (req_opcode),
      .req_operand_x (req_operand_x),
      .req_operand_y (req_operand_y),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_acc_value (rsp_acc_value)
   );

endmodule
`default_nettype wire

@@ sim/execute_checker.sv @@
`timescale 1ns / 1ps
module execute_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic                          req_type,
   input  wire logic [aie_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [aie_pkg::DATA_W-1:0]    req_operand_x,
   input  wire logic [aie_pkg::DATA_W-1:0]    req_operand_y,
   input  wire logic                          rsp_valid,
   input  wire logic [aie_pkg::STATUS_W-1:0]  rsp_status,
   input  wire logic [aie_pkg::DATA_W-1:0]    rsp_next_pc,
   input  wire logic [aie_pkg::DATA_W-1:0]    rsp_acc_value,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 checked_count
);
   import aie_pkg::*;

   typedef struct {
      status_type         status;
      logic [DATA_W-1:0]  next_pc;
      logic [DATA_W-1:0]  acc;
   } outcome_type;

   logic [DATA_W-1:0] reg_file [REG_COUNT];
   logic [BYTE_W-1:0] byte_mem [MEM_BYTES];
   logic [DATA_W-1:0] pc;
   outcome_type       expected_outcomes [$];

   // runs one word against the shadow machine state
   function automatic outcome_type execute_word(input logic kind,
                                                input logic [OPCODE_W-1:0] op,
                                                input logic [DATA_W-1:0] x,
                                                input logic [DATA_W-1:0] y);
      outcome_type       res;
      status_type        st;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic              x_reg;
      logic              y_reg;
      logic              x_mem;
      st    = ST_ADVANCED;
      a     = reg_file[0];
      b     = reg_file[1];
      x_reg = x < REG_COUNT;
      y_reg = y < REG_COUNT;
      x_mem = x < MEM_BYTES;
      if (kind == KIND_PRELOAD) begin
         if (x_mem) byte_mem[x[MEM_ADDR_W-1:0]] = y[BYTE_W-1:0];
         else st = ST_RANGE;
      end else begin
         case (op)
            OP_NOP: ;
            OP_ADD: reg_file[0] = a + b;
            OP_SUB: reg_file[0] = a - b;
            OP_OR:  reg_file[0] = (a != 0 || b != 0) ? 1 : 0;
            OP_AND: reg_file[0] = (a != 0 && b != 0) ? 1 : 0;
            OP_SHL: reg_file[0] = (b >= DATA_W) ? '0 : a << b[SHIFT_W-1:0];
            OP_SHR: reg_file[0] = (b >= DATA_W) ? '0 : a >> b[SHIFT_W-1:0];
            OP_LT:  reg_file[0] = (a < b) ? 1 : 0;
            OP_JMP: st = ST_JUMPED;
            OP_CJP: if (a != 0) st = ST_JUMPED;
            OP_SET: begin
               if (x_reg) reg_file[x[REG_IDX_W-1:0]] = y;
               else st = ST_RANGE;
            end
            OP_MOV: begin
               if (x_reg && y_reg)
                  reg_file[y[REG_IDX_W-1:0]] = reg_file[x[REG_IDX_W-1:0]];
               else st = ST_RANGE;
            end
            OP_LD: begin
               if (x_mem && y_reg)
                  reg_file[y[REG_IDX_W-1:0]] = {{(DATA_W-BYTE_W){1'b0}},
                                                byte_mem[x[MEM_ADDR_W-1:0]]};
               else st = ST_RANGE;
            end
            OP_ST: begin
               if (x_mem) byte_mem[x[MEM_ADDR_W-1:0]] = a[BYTE_W-1:0];
               else st = ST_RANGE;
            end
            OP_HALT: st = ST_HALTED;
            default: st = ST_UNKNOWN;
         endcase
         if (st == ST_JUMPED) pc = b;
         else if (st != ST_HALTED) pc = pc + 1;
      end
      res.status  = st;
      res.next_pc = pc;
      res.acc     = reg_file[0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) reg_file[i] = '0;
         for (int i = 0; i < MEM_BYTES; i++) byte_mem[i] = '0;
         pc = '0;
         expected_outcomes.delete();
      end else begin
         // results first: a word taken at this edge cannot answer at the same edge
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected result word, status %0d pc %h acc %h",
                        $time, rsp_status, rsp_next_pc, rsp_acc_value);
               fail_count++;
            end else begin
               want = expected_outcomes.pop_front();
               checked_count++;
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_next_pc !== want.next_pc) begin
                  $display("%0t: next_pc mismatch, expected %h, actual %h",
                           $time, want.next_pc, rsp_next_pc);
                  fail_count++;
               end
               if (rsp_acc_value !== want.acc) begin
                  $display("%0t: acc_value mismatch, expected %h, actual %h",
                           $time, want.acc, rsp_acc_value);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            expected_outcomes.push_back(execute_word(req_type, req_opcode,
                                                     req_operand_x, req_operand_y));
      end
      pending_count = expected_outcomes.size();
   end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import aie_pkg::*;

   localparam int RANDOM_WORDS   = 620;
   localparam int CALM_WORDS     = 100;    // tail of the run with no gaps
   localparam int WATCHDOG_LIMIT = 20000;  // covers the memory clearing sweep several times

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_type;
   logic [OPCODE_W-1:0]  req_opcode;
   logic [DATA_W-1:0]    req_operand_x;
   logic [DATA_W-1:0]    req_operand_y;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [DATA_W-1:0]    rsp_next_pc;
   logic [DATA_W-1:0]    rsp_acc_value;

   int fail_count;
   int pending_count;
   int checked_count;
   int quiet_cycles;
   int exec_words;
   int preload_words;
   int gap_percent;

   accumulator_isa_execute_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_opcode    (req_opcode),
      .req_operand_x (req_operand_x),
      .req_operand_y (req_operand_y),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_acc_value (rsp_acc_value)
   );

   // shadow machine and comparison live beside the block
   execute_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_opcode    (req_opcode),
      .req_operand_x (req_operand_x),
      .req_operand_y (req_operand_y),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_acc_value (rsp_acc_value),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: any accepted word or result strobe counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // often register 0/1, else any valid index, a few just past the end or huge
   function automatic logic [DATA_W-1:0] pick_reg();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return REG_COUNT + $urandom_range(0, 3);
         2, 3, 4: return $urandom_range(0, 1);
         default: return $urandom_range(0, REG_COUNT - 1);
      endcase
   endfunction

   // addresses cluster in a small window so loads see earlier stores
   function automatic logic [DATA_W-1:0] pick_addr();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return MEM_BYTES - 2 + $urandom_range(0, 3);
         2:       return $urandom_range(0, MEM_BYTES - 1);
         default: return $urandom_range(0, 31);
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic kind, input logic [OPCODE_W-1:0] op,
                            input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y);
      // optional idle burst before the word, start dropped for its length
      if ($urandom_range(1, 100) <= gap_percent) begin
         start = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      start         = 1'b1;
      req_type      = kind;
      req_opcode    = op;
      req_operand_x = x;
      req_operand_y = y;
      do @(posedge clock); while (busy);
      if (kind == KIND_PRELOAD) preload_words++;
      else exec_words++;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [OPCODE_W-1:0] op;
      logic [DATA_W-1:0]   x;
      logic [DATA_W-1:0]   y;
      int                  roll;
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = KIND_EXEC;
      req_opcode    = OP_NOP;
      req_operand_x = '0;
      req_operand_y = '0;
      gap_percent   = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      // the block sweeps its memory clear now; the first word simply waits on busy

      // directed part: preload edges, every opcode, wrap and range cases
      send_word(KIND_PRELOAD, 8'hFF, 0, 32'hFFFF_FFA5);        // upper bits ignored
      send_word(KIND_PRELOAD, OP_NOP, MEM_BYTES - 1, 32'h5A);
      send_word(KIND_PRELOAD, OP_NOP, MEM_BYTES, 32'h11);      // out of range
      send_word(KIND_EXEC, OP_SET, 0, 32'hFFFF_FFFF);
      send_word(KIND_EXEC, OP_SET, 1, 1);
      send_word(KIND_EXEC, OP_ADD, 0, 0);                      // wraps to zero
      send_word(KIND_EXEC, OP_SUB, 0, 0);                      // wraps to all ones
      send_word(KIND_EXEC, OP_SET, 1, 32);
      send_word(KIND_EXEC, OP_SHL, 0, 0);                      // large shift gives zero
      send_word(KIND_EXEC, OP_SET, 0, 32'h8000_0001);
      send_word(KIND_EXEC, OP_SET, 1, 31);
      send_word(KIND_EXEC, OP_SHR, 0, 0);
      send_word(KIND_EXEC, OP_LT, 0, 0);
      send_word(KIND_EXEC, OP_OR, 0, 0);
      send_word(KIND_EXEC, OP_AND, 0, 0);
      send_word(KIND_EXEC, OP_LD, 0, 0);                       // picks up the preloaded byte
      send_word(KIND_EXEC, OP_ST, MEM_BYTES - 1, 0);
      send_word(KIND_EXEC, OP_LD, MEM_BYTES - 1, REG_COUNT - 1);
      send_word(KIND_EXEC, OP_MOV, REG_COUNT - 1, 2);
      send_word(KIND_EXEC, OP_SET, REG_COUNT, 7);              // bad register index
      send_word(KIND_EXEC, OP_MOV, 0, 32'hFFFF_FFFF);
      send_word(KIND_EXEC, OP_LD, MEM_BYTES, 0);               // bad address
      send_word(KIND_EXEC, OP_ST, 32'hFFFF_FFFF, 0);
      send_word(KIND_EXEC, OP_SET, 0, 0);
      send_word(KIND_EXEC, OP_SET, 1, 32'hFFFF_FFFF);
      send_word(KIND_EXEC, OP_CJP, 0, 0);                      // untaken, accumulator zero
      send_word(KIND_EXEC, OP_JMP, 0, 0);                      // pc to all ones
      send_word(KIND_EXEC, OP_NOP, 0, 0);                      // pc wraps to zero
      send_word(KIND_EXEC, OP_HALT, 0, 0);
      send_word(KIND_EXEC, 8'd15, 0, 0);                       // lowest unknown code
      send_word(KIND_EXEC, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // random part: mostly valid opcodes with plausible operands
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0)
            gap_percent = (n >= RANDOM_WORDS - CALM_WORDS) ? 0 : $urandom_range(0, 2) * 30;
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            send_word(KIND_PRELOAD, OPCODE_W'($urandom_range(0, 255)), pick_addr(),
                      $urandom());
         end else begin
            if (roll < 14) op = OPCODE_W'($urandom_range(0, 255));
            else op = OPCODE_W'($urandom_range(OP_NOP, OP_HALT));
            case (op)
               OP_SET: begin
                  x = pick_reg();
                  // small immediates keep shift counts around the word width
                  y = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 40);
               end
               OP_MOV: begin
                  x = pick_reg();
                  y = pick_reg();
               end
               OP_LD: begin
                  x = pick_addr();
                  y = pick_reg();
               end
               OP_ST: begin
                  x = pick_addr();
                  y = $urandom();
               end
               default: begin
                  x = $urandom();
                  y = $urandom();
               end
            endcase
            send_word(KIND_EXEC, op, x, y);
         end
      end
      start = 1'b0;

      // drain: every expectation answered, then a wait for stray strobes
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);

      $display("covered %0d instruction words and %0d preload words", exec_words, preload_words);
      $display("%0d results compared, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ accumulator_isa_execute_unit.f @@
rtl/aie_pkg.sv
rtl/aie_ctrl.sv
rtl/aie_dpath.sv
rtl/accumulator_isa_execute_unit.sv
sim/execute_checker.sv
sim/testbench.sv
